FILE: src/format_string_integer_printer_assert.svh
// ----------------------------------------------------------------------------
// format_string_integer_printer_assert
// Assertion macros shared by the printer's RTL files. They expect clk_i and
// rst_ni in the scope of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef FORMAT_STRING_INTEGER_PRINTER_ASSERT_SVH
`define FORMAT_STRING_INTEGER_PRINTER_ASSERT_SVH

// property checked at every clock edge outside reset
`define FSIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must hold in the cycle after a trigger
`define FSIP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/fsip_pkg.sv
// ----------------------------------------------------------------------------
// fsip_pkg
// Shared types, constants and helpers of the integer format printer.
// ----------------------------------------------------------------------------
package fsip_pkg;

  localparam int unsigned MAX_LENGTH  = 1024;
  localparam int unsigned CMD_DEPTH   = 2;
  localparam int unsigned DIGIT_SLOTS = 10;
  localparam int unsigned HEX_DIGITS  = 8;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

  // ceil(2^35 / 10): floor(v / 10) == (v * RECIP_DIV10) >> 35 for any 32-bit v
  localparam logic [31:0] RECIP_DIV10 = 32'hCCCC_CCCD;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_DEC,
    CMD_HEX,
    CMD_LEN
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] value;
  } cmd_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] wide;
    wide = {4'b0000, d};
    if (d < 4'd10) begin
      return CH_ZERO + wide;
    end
    return CH_UPPER_A + wide - 8'd10;
  endfunction

endpackage

FILE: src/fsip_front.sv
// ----------------------------------------------------------------------------
// fsip_front
// Takes format bytes, tracks the pending '%' and turns each byte into at
// most one command for the back end.
// ----------------------------------------------------------------------------
module fsip_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     fmt_char_i,
  input  logic [31:0]    arg_value_i,
  output logic           cmd_valid_o,
  output fsip_pkg::cmd_t cmd_o
);

  logic pending_q;
  logic pending_d;

  always_comb begin
    pending_d   = pending_q;
    cmd_valid_o = 1'b0;
    cmd_o.kind  = fsip_pkg::CMD_CHAR;
    cmd_o.value = {24'd0, fmt_char_i};
    if (fmt_char_i == fsip_pkg::CH_NUL) begin
      pending_d   = 1'b0;
      cmd_valid_o = accept_i;
      cmd_o.kind  = fsip_pkg::CMD_LEN;
    end else if (!pending_q) begin
      if (fmt_char_i == fsip_pkg::CH_PERCENT) begin
        pending_d = 1'b1;
      end else begin
        cmd_valid_o = accept_i;
      end
    end else if (fmt_char_i != fsip_pkg::CH_PERCENT) begin
      // a second percent keeps the flag armed
      pending_d = 1'b0;
      case (fmt_char_i)
        fsip_pkg::CH_LOWER_D: begin
          cmd_valid_o = accept_i;
          cmd_o.kind  = fsip_pkg::CMD_DEC;
          cmd_o.value = arg_value_i;
        end
        fsip_pkg::CH_LOWER_X: begin
          cmd_valid_o = accept_i;
          cmd_o.kind  = fsip_pkg::CMD_HEX;
          cmd_o.value = arg_value_i;
        end
        fsip_pkg::CH_LOWER_C: begin
          cmd_valid_o = accept_i;
          cmd_o.value = {24'd0, arg_value_i[7:0]};
        end
        default: begin
          cmd_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else if (accept_i) begin
      pending_q <= pending_d;
    end
  end

endmodule

FILE: src/fsip_cmd_queue.sv
// ----------------------------------------------------------------------------
// fsip_cmd_queue
// Short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module fsip_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  fsip_pkg::cmd_t wr_cmd_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output logic           rd_valid_o,
  output fsip_pkg::cmd_t rd_cmd_o
);

  localparam int unsigned Depth = fsip_pkg::CMD_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  fsip_pkg::cmd_t       entry_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q;
  logic [PtrW-1:0]      rd_ptr_q;
  logic [CntW-1:0]      count_q;
  logic                 do_wr;
  logic                 do_rd;

  assign full_o     = (count_q == CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_cmd_o   = entry_q[rd_ptr_q];
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: src/fsip_back.sv
// ----------------------------------------------------------------------------
// fsip_back
// Carries out commands: echoes characters, converts numbers to digits,
// keeps the character count and drives the result register.
// ----------------------------------------------------------------------------
`include "format_string_integer_printer_assert.svh"

module fsip_back #(
  parameter int unsigned MaxLength = fsip_pkg::MAX_LENGTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  fsip_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           empty_o,
  input  logic           pop_i,
  output logic [7:0]     out_char_o,
  output logic           is_length_o,
  output logic [10:0]    total_length_o,
  output logic           last_o
);

  localparam int unsigned CntW       = $clog2(MaxLength + 1);
  localparam int unsigned DigitSlots = fsip_pkg::DIGIT_SLOTS;
  localparam int unsigned HexDigits  = fsip_pkg::HEX_DIGITS;
  localparam int unsigned DigitW     = $clog2(DigitSlots);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT,
    ST_HEX
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   cnt_q;
  logic [31:0]       mag_q;
  logic [28:0]       quo_q;
  logic              neg_q;
  logic [DigitW-1:0] n_q;
  logic [DigitW-1:0] idx_q;
  logic [3:0]        dbuf_q [DigitSlots];

  logic              out_valid_q;
  logic [7:0]        out_char_q;
  logic              out_isl_q;
  logic [10:0]       out_len_q;
  logic              out_last_q;

  logic              out_free;
  logic              emit_en;
  logic [7:0]        emit_ch;
  logic              emit_isl;
  logic              emit_last;
  logic [63:0]       prod;
  logic [3:0]        rem;
  logic [DigitW-1:0] hex_top;
  logic [3:0]        hex_nib;

  assign out_free = !out_valid_q || pop_i;
  assign prod     = mag_q * fsip_pkg::RECIP_DIV10;
  assign rem      = mag_q[3:0] - 4'(quo_q[3:0] * 4'd10);
  assign hex_nib  = mag_q[{idx_q[2:0], 2'b00} +: 4];

  // highest nonzero nibble, zero when the whole word is zero
  always_comb begin
    hex_top = '0;
    for (int i = 0; i < HexDigits; i++) begin
      if (cmd_i.value[i*4 +: 4] != 4'd0) begin
        hex_top = DigitW'(i);
      end
    end
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    emit_en   = 1'b0;
    emit_ch   = 8'd0;
    emit_isl  = 1'b0;
    emit_last = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind inside {fsip_pkg::CMD_DEC, fsip_pkg::CMD_HEX}) begin
            cmd_pop_o = 1'b1;
          end else if (out_free) begin
            cmd_pop_o = 1'b1;
            emit_en   = 1'b1;
            emit_last = 1'b1;
            emit_isl  = (cmd_i.kind == fsip_pkg::CMD_LEN);
            emit_ch   = emit_isl ? 8'd0 : cmd_i.value[7:0];
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit_en = 1'b1;
          if (neg_q) begin
            emit_ch = fsip_pkg::CH_MINUS;
          end else begin
            emit_ch   = fsip_pkg::digit_char(dbuf_q[idx_q]);
            emit_last = (idx_q == '0);
          end
        end
      end
      ST_HEX: begin
        if (out_free) begin
          emit_en   = 1'b1;
          emit_ch   = fsip_pkg::digit_char(hex_nib);
          emit_last = (idx_q == '0);
        end
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
  end

  // digit scratch, least significant digit first
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV) begin
      dbuf_q[n_q] <= rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      mag_q       <= '0;
      quo_q       <= '0;
      neg_q       <= 1'b0;
      n_q         <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_isl_q   <= 1'b0;
      out_len_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (emit_en) begin
        out_valid_q <= 1'b1;
        out_char_q  <= emit_ch;
        out_isl_q   <= emit_isl;
        out_len_q   <= emit_isl ? 11'(cnt_q) : 11'd0;
        out_last_q  <= emit_last;
        if (emit_isl) begin
          cnt_q <= '0;
        end else if (cnt_q < CntW'(MaxLength)) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o && cmd_i.kind == fsip_pkg::CMD_DEC) begin
            neg_q   <= cmd_i.value[31];
            mag_q   <= cmd_i.value[31] ? (~cmd_i.value + 32'd1) : cmd_i.value;
            n_q     <= '0;
            state_q <= ST_MUL;
          end else if (cmd_pop_o && cmd_i.kind == fsip_pkg::CMD_HEX) begin
            mag_q   <= cmd_i.value;
            idx_q   <= hex_top;
            state_q <= ST_HEX;
          end
        end
        ST_MUL: begin
          quo_q   <= prod[63:35];
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          mag_q <= {3'b000, quo_q};
          if (quo_q == '0 || n_q == DigitW'(DigitSlots - 1)) begin
            idx_q   <= n_q;
            state_q <= ST_EMIT;
          end else begin
            n_q     <= n_q + 1'b1;
            state_q <= ST_MUL;
          end
        end
        ST_EMIT: begin
          if (emit_en) begin
            if (neg_q) begin
              neg_q <= 1'b0;
            end else if (idx_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q - 1'b1;
            end
          end
        end
        ST_HEX: begin
          if (emit_en) begin
            if (idx_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q - 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign empty_o        = !out_valid_q;
  assign out_char_o     = out_char_q;
  assign is_length_o    = out_isl_q;
  assign total_length_o = out_len_q;
  assign last_o         = out_last_q;

  `FSIP_ASSERT(a_cnt_sat, cnt_q <= CntW'(MaxLength), "character count above limit")
  `FSIP_ASSERT_NEXT(a_len_clears, emit_en && emit_isl, cnt_q == '0, "count kept after length")
  `FSIP_ASSERT(a_hex_idx, state_q != ST_HEX || idx_q < DigitW'(HexDigits), "hex digit out of range")
  `FSIP_ASSERT(a_div_slot, state_q != ST_DIV || n_q < DigitW'(DigitSlots), "digit slot overrun")

endmodule

FILE: src/format_string_integer_printer.sv
// ----------------------------------------------------------------------------
// format_string_integer_printer
// Integer printf formatter: %d, %x and %c over a byte stream of format text.
// ----------------------------------------------------------------------------
// Input side is a queue: drive fmt_char_i and arg_value_i with push while
// full is low; each transfer carries one format byte and its argument.
// Result side is a queue too: while empty is low the oldest result sits on
// out_char_o, is_length_o, total_length_o and last_o; pop takes it.
// last_o marks the final result of one input byte; a NUL byte yields one
// length result (is_length_o high) and starts a new string.
// A plain byte or %c passes through the command queue and the result
// register and leaves one result. %x emits its digits (up to 8) from the
// highest nonzero nibble down. %d divides by ten through the reciprocal
// multiplier, one ST_MUL and one ST_DIV step per digit (up to ten), then
// emits the sign and digits, most significant first, via one result register.
// A two entry command queue lets new bytes be taken while a conversion runs
// or a result waits; when the receiver stalls, the result holds and full
// rises once the queue fills. Reset clears the pending percent, the count
// and all queues; no startup sweep is needed.
// ----------------------------------------------------------------------------
module format_string_integer_printer #(
  parameter int unsigned MaxLength = fsip_pkg::MAX_LENGTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  fmt_char_i,
  input  logic [31:0] arg_value_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char_o,
  output logic        is_length_o,
  output logic [10:0] total_length_o,
  output logic        last_o
);

  logic           accept;
  logic           fr_valid;
  fsip_pkg::cmd_t fr_cmd;
  logic           q_valid;
  fsip_pkg::cmd_t q_cmd;
  logic           q_pop;

  assign accept = push && !full;

  fsip_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .fmt_char_i  (fmt_char_i),
    .arg_value_i (arg_value_i),
    .cmd_valid_o (fr_valid),
    .cmd_o       (fr_cmd)
  );

  fsip_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (fr_valid),
    .wr_cmd_i   (fr_cmd),
    .full_o     (full),
    .rd_en_i    (q_pop),
    .rd_valid_o (q_valid),
    .rd_cmd_o   (q_cmd)
  );

  fsip_back #(
    .MaxLength (MaxLength)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (q_cmd),
    .cmd_pop_o      (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .out_char_o     (out_char_o),
    .is_length_o    (is_length_o),
    .total_length_o (total_length_o),
    .last_o         (last_o)
  );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the integer format printer. Format bytes with their
// argument words are pushed through the input queue and the produced text and
// length items are popped from the result queue. A scoreboard class predicts
// every item and compares each one, field by field, with what comes out.
// Both sides idle at random, with stretches of full-rate traffic.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned TOTAL_ITEMS = 120;

  typedef struct packed {
    logic [7:0]  ch;
    logic        is_len;
    logic [10:0] len;
    logic        last_item;
  } print_item_t;

  class printer_scoreboard;
    bit            pending_pct;
    int unsigned   written;
    print_item_t   text_q[$];
    print_item_t   batch[$];
    int unsigned   errors;

    function void put_text(logic [7:0] ch);
      print_item_t it;
      it = '{ch: ch, is_len: 1'b0, len: 11'd0, last_item: 1'b0};
      batch.push_back(it);
      if (written < fsip_pkg::MAX_LENGTH) written++;
    endfunction

    // digits are produced least significant first, emitted most significant first
    function void put_digits(logic [31:0] mag, int unsigned base);
      logic [3:0] digits[$];
      logic [7:0] d;
      do begin
        digits.push_front(4'(mag % base));
        mag = mag / base;
      end while (mag != 0 && digits.size() < fsip_pkg::DIGIT_SLOTS);
      foreach (digits[i]) begin
        d = {4'b0000, digits[i]};
        put_text(d < 8'd10 ? fsip_pkg::CH_ZERO + d : fsip_pkg::CH_UPPER_A + d - 8'd10);
      end
    endfunction

    // called on every accepted input transfer
    function void note_byte(logic [7:0] fmt, logic [31:0] arg);
      print_item_t it;
      batch.delete();
      if (fmt == fsip_pkg::CH_NUL) begin
        it = '{ch: 8'd0, is_len: 1'b1, len: written[10:0], last_item: 1'b1};
        text_q.push_back(it);
        pending_pct = 1'b0;
        written = 0;
        return;
      end
      if (!pending_pct) begin
        if (fmt == fsip_pkg::CH_PERCENT) begin
          pending_pct = 1'b1;
          return;
        end
        put_text(fmt);
      end else if (fmt != fsip_pkg::CH_PERCENT) begin
        pending_pct = 1'b0;
        case (fmt)
          fsip_pkg::CH_LOWER_D: begin
            if (arg[31]) begin
              put_text(fsip_pkg::CH_MINUS);
              put_digits(-arg, 10);
            end else begin
              put_digits(arg, 10);
            end
          end
          fsip_pkg::CH_LOWER_X: put_digits(arg, 16);
          fsip_pkg::CH_LOWER_C: put_text(arg[7:0]);
          default: ;
        endcase
      end
      if (batch.size() > 0) batch[batch.size() - 1].last_item = 1'b1;
      foreach (batch[i]) text_q.push_back(batch[i]);
    endfunction

    function void flag(string what, int unsigned exp_v, int unsigned got_v);
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected 0x%0h, got 0x%0h", what, exp_v, got_v);
    endfunction

    // called on every accepted result transfer
    function void check_result(print_item_t got);
      print_item_t want;
      if (text_q.size() == 0) begin
        flag("unexpected result, out_char", 0, got.ch);
        return;
      end
      want = text_q.pop_front();
      if (got.ch != want.ch) flag("out_char", want.ch, got.ch);
      if (got.is_len != want.is_len) flag("is_length", want.is_len, got.is_len);
      if (got.len != want.len) flag("total_length", want.len, got.len);
      if (got.last_item != want.last_item) flag("last", want.last_item, got.last_item);
    endfunction

    function int unsigned outstanding();
      return text_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  fmt_char_i;
  logic [31:0] arg_value_i;
  logic        empty;
  logic        pop;
  logic [7:0]  out_char_o;
  logic        is_length_o;
  logic [10:0] total_length_o;
  logic        last_o;

  printer_scoreboard sb;
  int unsigned       cycles;
  int unsigned       sent_items;
  bit                burst_in;
  bit                burst_out;

  format_string_integer_printer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .fmt_char_i     (fmt_char_i),
    .arg_value_i    (arg_value_i),
    .empty          (empty),
    .pop            (pop),
    .out_char_o     (out_char_o),
    .is_length_o    (is_length_o),
    .total_length_o (total_length_o),
    .last_o         (last_o)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // idle cycles before the next transfer, with occasional full-rate stretches
  function automatic int unsigned draw_wait(ref bit burst);
    if ($urandom_range(0, 31) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [31:0] pick_arg();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20);
      1: return -$urandom_range(1, 20);
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // push stays high across back-to-back transfers
  task automatic send_byte(logic [7:0] fmt, logic [31:0] arg);
    int unsigned gap;
    gap = draw_wait(burst_in);
    @(negedge clk_i);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push        <= 1'b1;
    fmt_char_i  <= fmt;
    arg_value_i <= arg;
    do @(posedge clk_i); while (full);
    sb.note_byte(fmt, arg);
    sent_items++;
  endtask

  task automatic send_conv(logic [7:0] letter, logic [31:0] arg);
    send_byte(fsip_pkg::CH_PERCENT, $urandom);
    send_byte(letter, arg);
  endtask

  task automatic drain_results();
    int unsigned stall;
    print_item_t got;
    forever begin
      stall = draw_wait(burst_out);
      @(negedge clk_i);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got = '{ch: out_char_o, is_len: is_length_o, len: total_length_o,
              last_item: last_o};
      sb.check_result(got);
    end
  endtask

  initial begin
    logic [7:0]  letter;
    int unsigned nseg;
    int unsigned r;
    sb          = new();
    cycles      = 0;
    sent_items  = 0;
    burst_in    = 1'b0;
    burst_out   = 1'b0;
    rst_ni      = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    fmt_char_i  = fsip_pkg::CH_NUL;
    arg_value_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    fork
      drain_results();
    join_none

    // directed: plain extremes, every conversion and the corner cases
    send_byte(8'h01, $urandom);
    send_byte(8'hFF, $urandom);
    send_conv(fsip_pkg::CH_LOWER_D, 32'h0000_0000);
    send_conv(fsip_pkg::CH_LOWER_D, 32'h7FFF_FFFF);
    send_conv(fsip_pkg::CH_LOWER_D, 32'h8000_0000);
    send_conv(fsip_pkg::CH_LOWER_D, 32'hFFFF_FFFF);
    send_conv(fsip_pkg::CH_LOWER_X, 32'hFFFF_FFFF);
    send_conv(fsip_pkg::CH_LOWER_X, 32'h0000_0000);
    send_conv(fsip_pkg::CH_LOWER_C, 32'h1234_5600);
    send_conv(8'h73, 32'hDEAD_BEEF);
    send_conv(8'hE9, $urandom);
    send_byte(fsip_pkg::CH_PERCENT, $urandom);
    send_conv(fsip_pkg::CH_LOWER_X, 32'h0000_0ABC);
    send_byte(fsip_pkg::CH_NUL, $urandom);
    send_byte(fsip_pkg::CH_PERCENT, $urandom);
    send_byte(fsip_pkg::CH_NUL, $urandom);

    // random strings: plain bytes and well-formed conversions, some noise
    while (sent_items < TOTAL_ITEMS) begin
      nseg = $urandom_range(0, 8);
      repeat (nseg) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          case ($urandom_range(0, 2))
            0: letter = fsip_pkg::CH_LOWER_D;
            1: letter = fsip_pkg::CH_LOWER_X;
            default: letter = fsip_pkg::CH_LOWER_C;
          endcase
          send_conv(letter, pick_arg());
        end else if (r < 55) begin
          send_conv(8'($urandom_range(0, 255)), pick_arg());
        end else if (r < 60) begin
          send_byte(fsip_pkg::CH_PERCENT, $urandom);
          send_conv(fsip_pkg::CH_LOWER_X, pick_arg());
        end else begin
          send_byte(8'($urandom_range(1, 255)), $urandom);
        end
      end
      if ($urandom_range(0, 9) != 0) send_byte(fsip_pkg::CH_NUL, $urandom);
    end
    @(negedge clk_i);
    push <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: format_string_integer_printer.f
+incdir+src
src/fsip_pkg.sv
src/fsip_front.sv
src/fsip_cmd_queue.sv
src/fsip_back.sv
src/format_string_integer_printer.sv
tb/testbench.sv
